/* rtl/core/sorted_timer_expiry_manager_defines.svh */
// ----------------------------------------------------------------------------
// Sorted timer expiry manager: assertion macros
// Shared concurrent assertion forms for the timer queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_EXPIRY_MANAGER_DEFINES_SVH
`define SORTED_TIMER_EXPIRY_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STEM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/stem_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted timer expiry manager package
// Shared constants, cell operation codes and chain control/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package stem_pkg;

  localparam int SLOT_BITS     = 4;
  localparam int NUM_IDS       = 1 << SLOT_BITS;
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int MAX_RESULTS   = 16;
  localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_FIND,
    CELL_SHIFT,
    CELL_MARK
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [SLOT_BITS-1:0]   match_slot;
  } chain_ctl_t;

  typedef struct packed {
    logic                   head_due;
    logic [SLOT_BITS-1:0]   head_slot;
    logic                   next_due;
    logic                   last_kill;
  } chain_sts_t;

endpackage

`default_nettype wire

/* rtl/core/stem_cell.sv */
// ----------------------------------------------------------------------------
// Timer queue cell
// Holds one entry of the sorted list and trades it with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module stem_cell #(
  parameter int TIME_BITS = stem_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stem_pkg::chain_ctl_t           ctl,
  input  logic [TIME_BITS-1:0]           now,
  input  logic [stem_pkg::SLOT_BITS-1:0] new_slot,
  input  logic [TIME_BITS-1:0]           new_expiry,
  input  logic [TIME_BITS-1:0]           new_period,
  input  logic                           left_valid,
  input  logic                           left_due,
  input  logic                           left_lt,
  input  logic                           left_kill,
  input  logic [stem_pkg::SLOT_BITS-1:0] left_slot,
  input  logic [TIME_BITS-1:0]           left_expiry,
  input  logic [TIME_BITS-1:0]           left_period,
  input  logic                           right_valid,
  input  logic                           right_due,
  input  logic [stem_pkg::SLOT_BITS-1:0] right_slot,
  input  logic [TIME_BITS-1:0]           right_expiry,
  input  logic [TIME_BITS-1:0]           right_period,
  output logic                           valid,
  output logic                           due,
  output logic                           kill,
  output logic                           lt,
  output logic [stem_pkg::SLOT_BITS-1:0] slot,
  output logic [TIME_BITS-1:0]           expiry,
  output logic [TIME_BITS-1:0]           period
);
  import stem_pkg::*;

  logic take_new;
  logic take_left;
  logic take_right;

  // An empty cell counts as later than any new entry; equal keys keep their place.
  assign lt = !valid || (new_expiry < expiry);

  assign take_new   = (ctl.op == CELL_INSERT) && lt && !left_lt;
  assign take_left  = (ctl.op == CELL_INSERT) && lt && left_lt;
  assign take_right = (ctl.op == CELL_POP) || ((ctl.op == CELL_SHIFT) && kill);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      due   <= 1'b0;
      kill  <= 1'b0;
    end else begin
      if (take_new) begin
        valid <= 1'b1;
        due   <= 1'b0;
      end else if (take_left) begin
        valid <= left_valid;
        due   <= left_due;
      end else if (take_right) begin
        valid <= right_valid;
        due   <= right_due;
      end
      case (ctl.op)
        CELL_FIND:  kill <= valid && (slot == ctl.match_slot);
        // pass the removal token one cell to the right
        CELL_SHIFT: kill <= kill ? 1'b0 : left_kill;
        CELL_MARK:  due  <= valid && (expiry <= now);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      slot   <= new_slot;
      expiry <= new_expiry;
      period <= new_period;
    end else if (take_left) begin
      slot   <= left_slot;
      expiry <= left_expiry;
      period <= left_period;
    end else if (take_right) begin
      slot   <= right_slot;
      expiry <= right_expiry;
      period <= right_period;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stem_chain.sv */
// ----------------------------------------------------------------------------
// Timer queue cell row
// Row of cells kept sorted by expiry; cell zero is the head of the list.
// ----------------------------------------------------------------------------
`default_nettype none

module stem_chain #(
  parameter int SLOTS     = stem_pkg::SLOTS_DEF,
  parameter int TIME_BITS = stem_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stem_pkg::chain_ctl_t           ctl,
  input  logic [TIME_BITS-1:0]           now,
  input  logic [stem_pkg::SLOT_BITS-1:0] new_slot,
  input  logic [TIME_BITS-1:0]           new_expiry,
  input  logic [TIME_BITS-1:0]           new_period,
  output stem_pkg::chain_sts_t           sts,
  output logic [TIME_BITS-1:0]           head_period
);
  import stem_pkg::*;

  logic                 v   [SLOTS];
  logic                 d   [SLOTS];
  logic                 k   [SLOTS];
  logic                 l   [SLOTS];
  logic [SLOT_BITS-1:0] s   [SLOTS];
  logic [TIME_BITS-1:0] e   [SLOTS];
  logic [TIME_BITS-1:0] p   [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                 lv, ld, llt, lk;
    logic [SLOT_BITS-1:0] ls;
    logic [TIME_BITS-1:0] le, lp;
    logic                 rv, rd;
    logic [SLOT_BITS-1:0] rs;
    logic [TIME_BITS-1:0] re, rp;

    if (i == 0) begin : g_first
      assign lv  = 1'b0;
      assign ld  = 1'b0;
      assign llt = 1'b0;
      assign lk  = 1'b0;
      assign ls  = '0;
      assign le  = '0;
      assign lp  = '0;
    end else begin : g_left
      assign lv  = v[i-1];
      assign ld  = d[i-1];
      assign llt = l[i-1];
      assign lk  = k[i-1];
      assign ls  = s[i-1];
      assign le  = e[i-1];
      assign lp  = p[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = 1'b0;
      assign rs = '0;
      assign re = '0;
      assign rp = '0;
    end else begin : g_right
      assign rv = v[i+1];
      assign rd = d[i+1];
      assign rs = s[i+1];
      assign re = e[i+1];
      assign rp = p[i+1];
    end

    stem_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .now          (now),
      .new_slot     (new_slot),
      .new_expiry   (new_expiry),
      .new_period   (new_period),
      .left_valid   (lv),
      .left_due     (ld),
      .left_lt      (llt),
      .left_kill    (lk),
      .left_slot    (ls),
      .left_expiry  (le),
      .left_period  (lp),
      .right_valid  (rv),
      .right_due    (rd),
      .right_slot   (rs),
      .right_expiry (re),
      .right_period (rp),
      .valid        (v[i]),
      .due          (d[i]),
      .kill         (k[i]),
      .lt           (l[i]),
      .slot         (s[i]),
      .expiry       (e[i]),
      .period       (p[i])
    );
  end

  if (SLOTS > 1) begin : g_next
    assign sts.next_due = d[1];
  end else begin : g_single
    assign sts.next_due = 1'b0;
  end

  assign sts.head_due  = d[0];
  assign sts.head_slot = s[0];
  assign sts.last_kill = k[SLOTS-1];
  assign head_period   = p[0];

endmodule

`default_nettype wire

/* rtl/core/sorted_timer_expiry_manager.sv */
// ----------------------------------------------------------------------------
// Sorted timer expiry manager
// Timer slots kept in a row of cells sorted by expiry, with one-shot and
// periodic arming, stop, query and tick-driven expiry reporting.
//
//   Channel  Dir  tdata bits (low first)                   tuser       tlast
//   s_axis   in   slot_id[3:0] duration_ms[35:4]           action[2:0] -
//                 now_ms[67:36], zero pad to 72
//   m_axis   out  slot_id_res[3:0] rearmed[4] is_active[5] kind        last
//                 zero pad to 8
//
// Arm of an idle slot: accept, then insert; query: accept, then answer once the
// output is free. Stop: accept, find, then shift until the removal token, which
// walks the cell row one cell per cycle, reaches the last cell; arm of an armed slot adds an insert.
// Tick: mark, then pop each due slot in order, with an insert after each periodic
// one; pops wait while the output is full.
// Synchronous reset clears all cell valid bits and active marks.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_timer_expiry_manager_defines.svh"

module sorted_timer_expiry_manager #(
  parameter int SLOTS     = stem_pkg::SLOTS_DEF,
  parameter int TIME_BITS = stem_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // slot_id, duration_ms, now_ms, pad
  input  logic [2:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // slot_id_res, rearmed, is_active, pad
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast
);
  import stem_pkg::*;

  localparam int SLOT_LSB = 0;
  localparam int DUR_LSB  = SLOT_LSB + SLOT_BITS;
  localparam int NOW_LSB  = DUR_LSB + 32;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ACT_ARM_ONCE = 3'd0,
    ACT_ARM_PER  = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_TICK     = 3'd3,
    ACT_QUERY    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_INSERT,
    S_MARK,
    S_POP,
    S_QRY
  } state_t;

  state_t               state;
  action_t              act;
  logic                 acc;
  logic [SLOT_BITS-1:0] in_slot;
  logic [TIME_BITS-1:0] in_dur;
  logic [TIME_BITS-1:0] in_now;
  logic                 slot_ok;

  logic [TIME_BITS-1:0] now_r;
  logic [SLOT_BITS-1:0] new_slot;
  logic [TIME_BITS-1:0] new_expiry;
  logic [TIME_BITS-1:0] new_period;
  logic                 ins_pend;
  logic                 in_tick;
  logic [CNT_BITS-1:0]  popped;
  logic [NUM_IDS-1:0]   active;

  logic                 out_valid;
  logic [SLOT_BITS-1:0] out_slot;
  logic                 out_kind;
  logic                 out_rearm;
  logic                 out_act;
  logic                 out_last;

  logic [TIME_BITS-1:0] add_a;
  logic [TIME_BITS-1:0] add_b;
  logic [TIME_BITS:0]   add_sum;
  logic [TIME_BITS-1:0] sat_sum;

  chain_ctl_t           ctl;
  chain_sts_t           sts;
  logic [TIME_BITS-1:0] head_period;
  logic                 out_free;
  logic                 out_load;
  logic                 popped_ok;
  logic                 pop_go;
  logic                 pop_last;
  logic                 head_rearm;

  assign act     = action_t'(s_axis_tuser);
  assign in_slot = s_axis_tdata[SLOT_LSB +: SLOT_BITS];
  assign in_dur  = TIME_BITS'(s_axis_tdata[DUR_LSB +: 32]);
  assign in_now  = TIME_BITS'(s_axis_tdata[NOW_LSB +: 32]);
  assign slot_ok = int'(in_slot) < SLOTS;

  assign s_axis_tready = (state == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;

  // One saturating adder: arm expiry at accept, re-arm expiry on a periodic pop.
  assign add_a   = (state == S_IDLE) ? in_now : now_r;
  assign add_b   = (state == S_IDLE) ? in_dur : head_period;
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign sat_sum = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];

  assign out_free   = !out_valid || m_axis_tready;
  assign popped_ok  = popped < CNT_BITS'(MAX_RESULTS);
  assign pop_go     = (state == S_POP) && sts.head_due && popped_ok && out_free;
  assign out_load   = pop_go || ((state == S_QRY) && out_free);
  assign head_rearm = (head_period != '0);
  assign pop_last   = !(sts.next_due &&
                        ((popped + CNT_BITS'(1)) < CNT_BITS'(MAX_RESULTS)));

  always_comb begin
    ctl.match_slot = new_slot;
    case (state)
      S_FIND:   ctl.op = CELL_FIND;
      S_SHIFT:  ctl.op = CELL_SHIFT;
      S_INSERT: ctl.op = CELL_INSERT;
      S_MARK:   ctl.op = CELL_MARK;
      S_POP:    ctl.op = pop_go ? CELL_POP : CELL_HOLD;
      default:  ctl.op = CELL_HOLD;
    endcase
  end

  stem_chain #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .now         (now_r),
    .new_slot    (new_slot),
    .new_expiry  (new_expiry),
    .new_period  (new_period),
    .sts         (sts),
    .head_period (head_period)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      out_valid <= 1'b0;
      ins_pend  <= 1'b0;
      in_tick   <= 1'b0;
      popped    <= '0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid && m_axis_tready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            now_r      <= in_now;
            new_slot   <= in_slot;
            new_expiry <= sat_sum;
            new_period <= (act == ACT_ARM_PER) ? in_dur : '0;
            case (act)
              ACT_ARM_ONCE, ACT_ARM_PER: begin
                if (slot_ok) begin
                  active[in_slot] <= 1'b1;
                  ins_pend        <= 1'b1;
                  in_tick         <= 1'b0;
                  state           <= active[in_slot] ? S_FIND : S_INSERT;
                end
              end
              ACT_STOP: begin
                if (slot_ok && active[in_slot]) begin
                  active[in_slot] <= 1'b0;
                  ins_pend        <= 1'b0;
                  state           <= S_FIND;
                end
              end
              ACT_TICK: begin
                in_tick <= 1'b1;
                state   <= S_MARK;
              end
              ACT_QUERY: state <= S_QRY;
              default: ;
            endcase
          end
        end
        S_FIND: state <= S_SHIFT;
        S_SHIFT: begin
          if (sts.last_kill) begin
            state <= ins_pend ? S_INSERT : S_IDLE;
          end
        end
        S_INSERT: state <= in_tick ? S_POP : S_IDLE;
        S_MARK: begin
          popped <= '0;
          state  <= S_POP;
        end
        S_POP: begin
          if (!sts.head_due || !popped_ok) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_slot   <= sts.head_slot;
            out_kind   <= KIND_EXPIRY;
            out_rearm  <= head_rearm;
            out_act    <= head_rearm;
            out_last   <= pop_last;
            popped     <= popped + CNT_BITS'(1);
            new_slot   <= sts.head_slot;
            new_expiry <= sat_sum;
            new_period <= head_period;
            if (head_rearm) begin
              state <= S_INSERT;
            end else begin
              active[sts.head_slot] <= 1'b0;
              if (pop_last) begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_QRY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_slot  <= new_slot;
            out_kind  <= KIND_QUERY;
            out_rearm <= 1'b0;
            out_act   <= active[new_slot];
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_act, out_rearm, out_slot};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  `STEM_ASSERT_NEXT(a_pop_emits, clk, rst, pop_go, m_axis_tvalid,
    "pop without result")
  `STEM_ASSERT_IMPLIES(a_query_last, clk, rst,
    m_axis_tvalid && (m_axis_tuser == KIND_QUERY),
    m_axis_tlast && !m_axis_tdata[4], "query answer not single")
  `STEM_ASSERT_IMPLIES(a_stop_cleared, clk, rst, (state == S_SHIFT) && !ins_pend,
    !active[new_slot], "stopped slot still active")
  `STEM_ASSERT_IMPLIES(a_pop_bound, clk, rst, state == S_POP,
    popped <= CNT_BITS'(MAX_RESULTS), "too many results in one tick")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer expiry manager testbench
// Streams arm, stop, tick and query commands with random gaps on both sides,
// tracks the sorted timer list alongside the block and checks every expiry
// event and query answer in order, field by field.
// ----------------------------------------------------------------------------

module testbench;

  import stem_pkg::*;

  localparam int NSLOTS       = SLOTS_DEF;
  localparam int WATCHDOG_MAX = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 80;
  localparam int RANDOM_CMDS  = 270;
  localparam int REPORT_CAP   = 20;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ACT_ARM_ONCE,
    ACT_ARM_PERIODIC,
    ACT_STOP,
    ACT_TICK,
    ACT_QUERY,
    ACT_SPARE5,
    ACT_SPARE6,
    ACT_SPARE7
  } timer_act_t;

  typedef struct packed {
    timer_act_t  action;
    logic [3:0]  slot;
    logic [31:0] dur;
    logic [31:0] now;
  } timer_cmd_t;

  typedef struct packed {
    logic [3:0] slot;
    logic       kind;
    logic       rearmed;
    logic       active;
    logic       last;
  } timer_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // slot_id, duration_ms, now_ms, pad
  logic [2:0]  s_axis_tuser = '0;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // slot_id_res, rearmed, is_active, pad
  logic        m_axis_tuser;        // kind
  logic        m_axis_tlast;

  sorted_timer_expiry_manager uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Shadow timer state
  logic [31:0]  exp_time [NSLOTS];
  logic [31:0]  per_val  [NSLOTS];
  bit           act_mark [NSLOTS];
  int unsigned  order_q[$];

  timer_cmd_t   cmd_queue[$];
  timer_event_t expected_events[$];

  int act_hits[8];
  int expiries_seen   = 0;
  int rearms_seen     = 0;
  int max_tick_events = 0;
  int events_checked  = 0;
  int fail_count      = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void order_remove(int unsigned s);
    for (int i = 0; i < order_q.size(); i++) begin
      if (order_q[i] == s) begin
        order_q.delete(i);
        return;
      end
    end
  endfunction

  // A newcomer goes behind every entry with an equal expiry
  function automatic void order_insert(int unsigned s);
    int p;
    p = 0;
    if (order_q.size() >= NSLOTS) return;
    while (p < order_q.size() && !(exp_time[s] < exp_time[order_q[p]])) p++;
    order_q.insert(p, s);
  endfunction

  function automatic void predict_events(timer_cmd_t c);
    int           due;
    int unsigned  s;
    bit           again;
    timer_event_t ev;
    act_hits[c.action]++;
    case (c.action)
      ACT_ARM_ONCE, ACT_ARM_PERIODIC: begin
        if (act_mark[c.slot]) order_remove(c.slot);
        exp_time[c.slot] = sat_add(c.now, c.dur);
        per_val[c.slot]  = (c.action == ACT_ARM_PERIODIC) ? c.dur : 32'd0;
        act_mark[c.slot] = 1'b1;
        order_insert(c.slot);
      end
      ACT_STOP: begin
        if (act_mark[c.slot]) begin
          order_remove(c.slot);
          act_mark[c.slot] = 1'b0;
        end
      end
      ACT_TICK: begin
        // Count due slots up front so a re-armed slot is not reported twice
        due = 0;
        while (due < order_q.size() && exp_time[order_q[due]] <= c.now) due++;
        if (due > MAX_RESULTS) due = MAX_RESULTS;
        if (due > max_tick_events) max_tick_events = due;
        for (int i = 0; i < due; i++) begin
          s     = order_q[0];
          again = (per_val[s] != 32'd0);
          order_q.delete(0);
          if (again) begin
            exp_time[s] = sat_add(c.now, per_val[s]);
            order_insert(s);
            rearms_seen++;
          end else begin
            act_mark[s] = 1'b0;
          end
          expiries_seen++;
          ev = '{slot: s[3:0], kind: KIND_EXPIRY, rearmed: again, active: again,
                 last: (i == due - 1)};
          expected_events.push_back(ev);
        end
      end
      ACT_QUERY: begin
        ev = '{slot: c.slot, kind: KIND_QUERY, rearmed: 1'b0,
               active: act_mark[c.slot], last: 1'b1};
        expected_events.push_back(ev);
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm = $urandom_range(20, 40);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_cmd(timer_act_t a, logic [3:0] s, logic [31:0] d,
                                   logic [31:0] n);
    cmd_queue.push_back('{action: a, slot: s, dur: d, now: n});
  endfunction

  task automatic build_directed();
    push_cmd(ACT_QUERY,        4'd0,  32'd0,          32'd0);
    push_cmd(ACT_TICK,         4'd0,  32'd0,          32'd0);   // empty list
    push_cmd(ACT_ARM_ONCE,     4'd0,  32'd0,          32'd0);
    push_cmd(ACT_TICK,         4'd0,  32'd0,          32'd0);
    push_cmd(ACT_ARM_PERIODIC, 4'd15, 32'd0,          32'd7);   // zero period
    push_cmd(ACT_QUERY,        4'd15, 32'd0,          32'd7);
    push_cmd(ACT_TICK,         4'd15, 32'd0,          32'd7);
    push_cmd(ACT_ARM_ONCE,     4'd3,  32'hFFFF_FFFF,  32'd100); // saturates
    push_cmd(ACT_ARM_PERIODIC, 4'd4,  32'hFFFF_FFF0,  32'h20);  // saturates
    push_cmd(ACT_ARM_PERIODIC, 4'd9,  32'd5,          32'd10);
    push_cmd(ACT_ARM_ONCE,     4'd10, 32'd5,          32'd10);  // tie behind 9
    push_cmd(ACT_ARM_ONCE,     4'd9,  32'd3,          32'd10);  // re-arm armed slot
    push_cmd(ACT_TICK,         4'd0,  32'd0,          32'd14);
    push_cmd(ACT_ARM_PERIODIC, 4'd6,  32'd1,          32'd20);
    push_cmd(ACT_ARM_PERIODIC, 4'd7,  32'd2,          32'd20);
    push_cmd(ACT_TICK,         4'd0,  32'd0,          32'd25);
    push_cmd(ACT_STOP,         4'd6,  32'd0,          32'd25);
    push_cmd(ACT_STOP,         4'd6,  32'd0,          32'd25);  // already stopped
    push_cmd(ACT_QUERY,        4'd6,  32'd0,          32'd25);
    // 7 re-arms to the saturated time and must still be reported only once
    push_cmd(ACT_TICK,         4'd0,  32'd0,          32'hFFFF_FFFF);
    push_cmd(ACT_SPARE5,       4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    push_cmd(ACT_SPARE7,       4'd5,  32'hFFFF_FFFF,  32'd0);
    push_cmd(ACT_QUERY,        4'd4,  32'd0,          32'd30);
    push_cmd(ACT_STOP,         4'd4,  32'd0,          32'd30);
    push_cmd(ACT_STOP,         4'd7,  32'd0,          32'd30);
    push_cmd(ACT_QUERY,        4'd7,  32'd0,          32'd30);
  endtask

  task automatic build_random();
    int          made;
    int          r;
    int          n;
    timer_act_t  a;
    logic [31:0] t;
    logic [31:0] d;
    logic [31:0] nw;
    made = 0;
    t    = 32'd1000;
    while (made < RANDOM_CMDS) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // Fill every slot, then one tick that finds them all due
        for (int s = 0; s < NSLOTS; s++)
          push_cmd(timer_act_t'($urandom_range(0, 1)), s[3:0], $urandom_range(1, 8), t);
        t = t + $urandom_range(8, 20);
        push_cmd(ACT_TICK, 4'($urandom_range(0, 15)), $urandom, t);
        made += NSLOTS + 1;
      end else begin
        if (r < 5) t = $urandom;
        else if (r < 7) t = 32'hFFFF_FF00 + $urandom_range(0, 255);
        else t = t + $urandom_range(0, 6);
        n = $urandom_range(0, 99);
        if (n < 22) a = ACT_ARM_ONCE;
        else if (n < 44) a = ACT_ARM_PERIODIC;
        else if (n < 54) a = ACT_STOP;
        else if (n < 82) a = ACT_TICK;
        else if (n < 95) a = ACT_QUERY;
        else a = timer_act_t'($urandom_range(5, 7));
        case ($urandom_range(0, 9))
          0:       d = 32'd0;
          1:       d = $urandom;
          2:       d = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: d = $urandom_range(1, 30);
        endcase
        nw = ($urandom_range(0, 9) == 0) ? $urandom : t;
        push_cmd(a, 4'($urandom_range(0, 15)), d, nw);
        if (a <= ACT_QUERY) made++;
      end
    end
  endtask

  // Command driver
  timer_cmd_t cur_cmd;
  int         tx_gap  = 0;
  int         tx_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_events(cur_cmd);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current transfer
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        cur_cmd = cmd_queue.pop_front();
        s_axis_tdata  <= {4'd0, cur_cmd.now, cur_cmd.dur, cur_cmd.slot};
        s_axis_tuser  <= cur_cmd.action;
        s_axis_tvalid <= 1'b1;
        tx_gap = pick_gap(tx_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off to back the block up
  int  rx_stall   = 0;
  int  rx_calm    = 0;
  int  rx_seen    = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) rx_seen++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && rx_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) rx_stall = pick_gap(rx_calm);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    timer_event_t got;
    timer_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{slot: m_axis_tdata[3:0], kind: m_axis_tuser, rearmed: m_axis_tdata[4],
              active: m_axis_tdata[5], last: m_axis_tlast};
      events_checked++;
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP)
          $display("%0t: unexpected result slot=%0d kind=%0d rearmed=%0d active=%0d last=%0d",
                   $time, got.slot, got.kind, got.rearmed, got.active, got.last);
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t: mismatch slot/kind/rearmed/active/last expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     $time, want.slot, want.kind, want.rearmed, want.active, want.last,
                     got.slot, got.kind, got.rearmed, got.active, got.last);
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no transfer for %0d cycles, %0d results still expected",
               $time, quiet_cycles, expected_events.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NSLOTS; i++) act_mark[i] = 1'b0;
    foreach (act_hits[i]) act_hits[i] = 0;
    build_directed();
    build_random();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (cmd_queue.size() != 0 || s_axis_tvalid || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d arm-once, %0d periodic arms, %0d stops, %0d ticks, %0d queries, %0d spare codes.",
             act_hits[ACT_ARM_ONCE], act_hits[ACT_ARM_PERIODIC], act_hits[ACT_STOP],
             act_hits[ACT_TICK], act_hits[ACT_QUERY],
             act_hits[ACT_SPARE5] + act_hits[ACT_SPARE6] + act_hits[ACT_SPARE7]);
    $display("Checked %0d results: %0d expiries, %0d periodic re-arms, up to %0d per tick; %0d errors.",
             events_checked, expiries_seen, rearms_seen, max_tick_events, fail_count);
    if (fail_count == 0 && expected_events.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
